FILE: design/circumcircle_from_three_points_defines.svh
// assertion macros for the circumcircle block
`ifndef CIRCUMCIRCLE_FROM_THREE_POINTS_DEFINES_SVH
`define CIRCUMCIRCLE_FROM_THREE_POINTS_DEFINES_SVH
`ifndef SYNTHESIS
`define CCP_ASSERT_IMPL(name, ant, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("ccp assertion failed");
`define CCP_ASSERT_NEXT(name, ant, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("ccp assertion failed");
`else
`define CCP_ASSERT_IMPL(name, ant, cons)
`define CCP_ASSERT_NEXT(name, ant, cons)
`endif
`endif

FILE: design/ccp_pkg.sv
// shared constants for the circumcircle block
`timescale 1ns / 1ps
package ccp_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int ADDR_BITS = 3;
  localparam logic [0:0] REG_SINE_THRESHOLD = 1'b0;
  localparam logic [15:0] THRESH_RESET = 16'd7;
  localparam int SINE_SHIFT = 32;
  localparam int TH2_BITS = 32;
  localparam int MUL_CHUNK = 32;
  localparam int MUL_LAT = 5;
  localparam int QUO_BITS = 33;
  localparam int ROOT_BITS = QUO_BITS + 2;
endpackage

FILE: design/ccp_mul.sv
// pipelined signed multiplier built from chunk partial products
`timescale 1ns / 1ps
module ccp_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                  clk,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0] p
);
  import ccp_pkg::*;

  localparam int K = MUL_CHUNK;
  localparam int NA = (AW + K - 1) / K;
  localparam int NB = (BW + K - 1) / K;
  localparam int PW = AW + BW;
  localparam int ROWW = NB * K + K;

  logic [AW-1:0] a_abs;
  logic [BW-1:0] b_abs;
  logic [NA*K-1:0] am;
  logic [NB*K-1:0] bm;
  logic neg0, neg1, neg2, neg3;
  logic [2*K-1:0] pp [NA][NB];
  logic [ROWW-1:0] row_next [NA];
  logic [ROWW-1:0] row [NA];
  logic [PW-1:0] sum_next;
  logic [PW-1:0] sum;

  always_comb begin
    a_abs = a[AW-1] ? AW'(-a) : AW'(a);
    b_abs = b[BW-1] ? BW'(-b) : BW'(b);
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (ROWW'(pp[i][j]) << (K * j));
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NA; i++) begin
      sum_next = sum_next + (PW'(row[i]) << (K * i));
    end
  end

  always_ff @(posedge clk) begin
    am <= (NA*K)'(a_abs);
    bm <= (NB*K)'(b_abs);
    neg0 <= a[AW-1] ^ b[BW-1];
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp[i][j] <= (2*K)'(am[i*K +: K]) * (2*K)'(bm[j*K +: K]);
      end
    end
    neg1 <= neg0;
    row <= row_next;
    neg2 <= neg1;
    sum <= sum_next;
    neg3 <= neg2;
    p <= neg3 ? -sum : sum;
  end
endmodule

FILE: design/ccp_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
module ccp_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] q,
  output logic          ovf
);
  import ccp_pkg::*;

  localparam int RMW = DW + QW;
  localparam int XW = (NW > RMW) ? NW : RMW;

  logic [XW-1:0] numx;
  logic [RMW-1:0] rem [QW];
  logic [DW-1:0] dn [QW];
  logic [QW-1:0] qq [QW+1];
  logic ov [QW+1];

  assign numx = XW'(num);

  always_ff @(posedge clk) begin
    rem[0] <= RMW'(numx);
    dn[0] <= den;
    qq[0] <= '0;
    ov[0] <= (numx >> QW) >= XW'(den);
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [RMW-1:0] sh;
    logic fit;
    assign sh = RMW'(dn[k-1]) << B;
    assign fit = rem[k-1] >= sh;
    always_ff @(posedge clk) begin
      qq[k] <= fit ? (qq[k-1] | (QW'(1) << B)) : qq[k-1];
      ov[k] <= ov[k-1];
    end
    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k] <= fit ? rem[k-1] - sh : rem[k-1];
        dn[k] <= dn[k-1];
      end
    end
  end

  assign q = qq[QW];
  assign ovf = ov[QW];
endmodule

FILE: design/circumcircle_from_three_points.sv
// circumcircle of three points: top level with alignment test, division and root
//
// Requests enter on start with the six coordinates ax, ay, bx, by, cx_in, cy_in
// (signed fixed point, COORD_BITS wide). A request is taken at every clock
// edge where start is high and busy is low; busy is high only while rst is.
// One request per clock is sustained; each gives exactly one result.
// Each request's result is registered at the output and shown for one cycle
// with done high: center_x, center_y, circle_radius, aligned_error, saturated.
// The pipeline holds the 33 quotient stages of the center dividers and
// the 35 digit stages of the radius root, plus the multiplier pipelines.
// Aligned points give aligned_error with all other fields zero.
// The receiver cannot stall; results are never held back.
// sine_threshold sits at address 0 of the APB port, reset value 7; write it
// only while no request is in flight.
// A synchronous reset clears all in-flight requests and sets the threshold back to 7.
`timescale 1ns / 1ps
`include "circumcircle_from_three_points_defines.svh"
module circumcircle_from_three_points #(
  parameter int COORD_BITS = ccp_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx_in,
  input  logic signed [COORD_BITS-1:0] cy_in,
  output logic                         done,
  output logic signed [31:0]           center_x,
  output logic signed [31:0]           center_y,
  output logic [31:0]                  circle_radius,
  output logic                         aligned_error,
  output logic                         saturated,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ccp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ccp_pkg::*;

  localparam int C = COORD_BITS;
  localparam int D = C + 1;
  localparam int P = 2 * D;
  localparam int W3 = P + 1;
  localparam int NPW = D + W3;
  localparam int NXW = NPW + 1;
  localparam int NW = NXW + 1;
  localparam int DW = W3 + 1;
  localparam int QW = QUO_BITS;
  localparam int RT = ROOT_BITS;
  localparam int CW = QW + 2;
  localparam int ML = MUL_LAT;
  localparam int DL = QW + 1;
  localparam int RHW = 2 * W3 + TH2_BITS + 1;
  localparam int AL_N = DL + 2 - ML;
  localparam int LAT = ML + DL + RT + 8;
  localparam int S3W = 2 * C + W3;
  localparam int S6W = 2 * C + 2;
  localparam int S9W = 32 + 32 + 3;
  localparam logic signed [CW-1:0] CMAX = CW'(32'sh7FFF_FFFF);
  localparam logic signed [CW-1:0] CMIN = CW'(32'sh8000_0000);

  // configuration
  logic [15:0] sine_threshold;
  logic [TH2_BITS-1:0] th2;
  logic cfg_wr;

  assign pready = 1'b1;
  assign busy = rst;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_BITS-1:2] == REG_SINE_THRESHOLD);
  assign prdata = (paddr[ADDR_BITS-1:2] == REG_SINE_THRESHOLD) ? 32'(sine_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_threshold <= THRESH_RESET;
    end else if (cfg_wr) begin
      sine_threshold <= pwdata[15:0];
    end
    th2 <= TH2_BITS'(sine_threshold) * TH2_BITS'(sine_threshold);
  end

  // valid chain
  logic vld [1:LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAT; k++) vld[k] <= 1'b0;
    end else begin
      vld[1] <= start && !busy;
      for (int k = 2; k <= LAT; k++) vld[k] <= vld[k-1];
    end
  end

  assign done = vld[LAT];

  // edge vectors
  logic signed [D-1:0] ux, uy, vx, vy, ex, ey;
  logic signed [C-1:0] ax1, ay1;

  always_ff @(posedge clk) begin
    ux <= D'(bx) - D'(ax);
    uy <= D'(by) - D'(ay);
    vx <= D'(cx_in) - D'(ax);
    vy <= D'(cy_in) - D'(ay);
    ex <= D'(cx_in) - D'(bx);
    ey <= D'(cy_in) - D'(by);
    ax1 <= ax;
    ay1 <= ay;
  end

  // products
  logic signed [P-1:0] uxx, uyy, exx, eyy, vxx, vyy, uyex, uxey, uxvy, uyvx;
  logic signed [D-1:0] ux2, uy2, vx2, vy2;
  logic signed [C-1:0] ax2, ay2;
  logic z2;

  always_ff @(posedge clk) begin
    uxx <= P'(ux) * P'(ux);
    uyy <= P'(uy) * P'(uy);
    exx <= P'(ex) * P'(ex);
    eyy <= P'(ey) * P'(ey);
    vxx <= P'(vx) * P'(vx);
    vyy <= P'(vy) * P'(vy);
    uyex <= P'(uy) * P'(ex);
    uxey <= P'(ux) * P'(ey);
    uxvy <= P'(ux) * P'(vy);
    uyvx <= P'(uy) * P'(vx);
    z2 <= (ux == '0 && uy == '0) || (ex == '0 && ey == '0);
    ux2 <= ux;
    uy2 <= uy;
    vx2 <= vx;
    vy2 <= vy;
    ax2 <= ax1;
    ay2 <= ay1;
  end

  // squared lengths, cross product and determinant
  logic signed [W3-1:0] l1, l2, nv, cr, dd;
  logic signed [D-1:0] ux3, uy3, vx3, vy3;
  logic signed [C-1:0] ax3, ay3;
  logic z3;

  always_ff @(posedge clk) begin
    l1 <= W3'(uxx) + W3'(uyy);
    l2 <= W3'(exx) + W3'(eyy);
    nv <= W3'(vxx) + W3'(vyy);
    cr <= W3'(uyex) - W3'(uxey);
    dd <= W3'(uxvy) - W3'(uyvx);
    z3 <= z2 || (uyex == uxey);
    ux3 <= ux2;
    uy3 <= uy2;
    vx3 <= vx2;
    vy3 <= vy2;
    ax3 <= ax2;
    ay3 <= ay2;
  end

  // wide products
  logic signed [2*W3-1:0] cr2, ll;
  logic signed [NPW-1:0] n1, n2, n3, n4;
  logic signed [RHW-1:0] rhs;
  logic signed [TH2_BITS:0] th2s;

  assign th2s = {1'b0, th2};

  ccp_mul #(.AW(W3), .BW(W3)) u_mul_cr (.clk(clk), .a(cr), .b(cr), .p(cr2));
  ccp_mul #(.AW(W3), .BW(W3)) u_mul_ll (.clk(clk), .a(l1), .b(l2), .p(ll));
  ccp_mul #(.AW(D), .BW(W3)) u_mul_n1 (.clk(clk), .a(vy3), .b(l1), .p(n1));
  ccp_mul #(.AW(D), .BW(W3)) u_mul_n2 (.clk(clk), .a(uy3), .b(nv), .p(n2));
  ccp_mul #(.AW(D), .BW(W3)) u_mul_n3 (.clk(clk), .a(ux3), .b(nv), .p(n3));
  ccp_mul #(.AW(D), .BW(W3)) u_mul_n4 (.clk(clk), .a(vx3), .b(l1), .p(n4));
  ccp_mul #(.AW(TH2_BITS+1), .BW(2*W3)) u_mul_rhs (.clk(clk), .a(th2s), .b(ll), .p(rhs));

  // alignment test
  logic signed [2*W3-1:0] cr2_d [1:ML];
  logic z_d [1:2*ML];
  logic al_d [0:AL_N];
  logic [RHW-1:0] lhs;

  assign lhs = RHW'(unsigned'(cr2_d[ML])) << SINE_SHIFT;

  always_ff @(posedge clk) begin
    cr2_d[1] <= cr2;
    for (int k = 2; k <= ML; k++) cr2_d[k] <= cr2_d[k-1];
    z_d[1] <= z3;
    for (int k = 2; k <= 2*ML; k++) z_d[k] <= z_d[k-1];
    al_d[0] <= z_d[2*ML] || (lhs < unsigned'(rhs));
    for (int k = 1; k <= AL_N; k++) al_d[k] <= al_d[k-1];
  end

  // numerators
  logic [S3W-1:0] sd3 [1:ML+1];
  logic signed [NXW-1:0] nx, ny;
  logic signed [W3-1:0] d5;
  logic signed [C-1:0] ax5, ay5;

  assign {ax5, ay5, d5} = sd3[ML+1];

  always_ff @(posedge clk) begin
    sd3[1] <= {ax3, ay3, dd};
    for (int k = 2; k <= ML+1; k++) sd3[k] <= sd3[k-1];
    nx <= NXW'(n1) - NXW'(n2);
    ny <= NXW'(n3) - NXW'(n4);
  end

  // rounded division setup
  logic [NXW-1:0] nxm, nym;
  logic [W3-1:0] dm;
  logic [NW-1:0] numx, numy;
  logic [DW-1:0] den;
  logic sx6, sy6;
  logic signed [C-1:0] ax6, ay6;

  always_comb begin
    nxm = nx[NXW-1] ? NXW'(-nx) : NXW'(nx);
    nym = ny[NXW-1] ? NXW'(-ny) : NXW'(ny);
    dm = d5[W3-1] ? W3'(-d5) : W3'(d5);
  end

  always_ff @(posedge clk) begin
    numx <= NW'(nxm) + NW'(dm);
    numy <= NW'(nym) + NW'(dm);
    den <= DW'(dm) << 1;
    sx6 <= nx[NXW-1] ^ d5[W3-1];
    sy6 <= ny[NXW-1] ^ d5[W3-1];
    ax6 <= ax5;
    ay6 <= ay5;
  end

  logic [QW-1:0] qx, qy;
  logic ovx, ovy;

  ccp_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
    .clk(clk), .num(numx), .den(den), .q(qx), .ovf(ovx)
  );
  ccp_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
    .clk(clk), .num(numy), .den(den), .q(qy), .ovf(ovy)
  );

  logic [S6W-1:0] sd6 [1:DL];

  always_ff @(posedge clk) begin
    sd6[1] <= {ax6, ay6, sx6, sy6};
    for (int k = 2; k <= DL; k++) sd6[k] <= sd6[k-1];
  end

  // signed offsets and their squares
  logic signed [C-1:0] p1_ax, p1_ay;
  logic p1_sx, p1_sy, p1_ovx, p1_ovy;
  logic signed [QW:0] p1_ox, p1_oy;
  logic [2*QW-1:0] p1_oxx, p1_oyy;

  always_ff @(posedge clk) begin
    {p1_ax, p1_ay, p1_sx, p1_sy} <= sd6[DL];
    p1_ox <= sd6[DL][1] ? -((QW+1)'(qx)) : (QW+1)'(qx);
    p1_oy <= sd6[DL][0] ? -((QW+1)'(qy)) : (QW+1)'(qy);
    p1_oxx <= (2*QW)'(qx) * (2*QW)'(qx);
    p1_oyy <= (2*QW)'(qy) * (2*QW)'(qy);
    p1_ovx <= ovx;
    p1_ovy <= ovy;
  end

  // center with saturation
  logic signed [CW-1:0] cxw, cyw;
  logic [31:0] cxo, cyo;
  logic satx, saty;

  always_comb begin
    cxw = CW'(p1_ax) + CW'(p1_ox);
    cyw = CW'(p1_ay) + CW'(p1_oy);
    if (p1_ovx) begin
      cxo = p1_sx ? 32'h8000_0000 : 32'h7FFF_FFFF;
      satx = 1'b1;
    end else if (cxw > CMAX) begin
      cxo = 32'h7FFF_FFFF;
      satx = 1'b1;
    end else if (cxw < CMIN) begin
      cxo = 32'h8000_0000;
      satx = 1'b1;
    end else begin
      cxo = cxw[31:0];
      satx = 1'b0;
    end
    if (p1_ovy) begin
      cyo = p1_sy ? 32'h8000_0000 : 32'h7FFF_FFFF;
      saty = 1'b1;
    end else if (cyw > CMAX) begin
      cyo = 32'h7FFF_FFFF;
      saty = 1'b1;
    end else if (cyw < CMIN) begin
      cyo = 32'h8000_0000;
      saty = 1'b1;
    end else begin
      cyo = cyw[31:0];
      saty = 1'b0;
    end
  end

  // radius root, one digit per stage
  logic [2*RT-1:0] sq_x [RT];
  logic [RT+1:0] sq_rem [RT];
  logic [RT-1:0] sq_root [RT+1];
  logic [S9W-1:0] sd9 [0:RT];

  always_ff @(posedge clk) begin
    sq_x[0] <= ((2*RT)'(p1_oxx) + (2*RT)'(p1_oyy)) << 2;
    sq_rem[0] <= '0;
    sq_root[0] <= '0;
    sd9[0] <= {cxo, cyo, satx || saty, p1_ovx || p1_ovy, al_d[AL_N]};
    for (int k = 1; k <= RT; k++) sd9[k] <= sd9[k-1];
  end

  for (genvar k = 1; k <= RT; k++) begin : g_sqrt
    localparam int B = RT - k;
    logic [RT+1:0] r_in, trial;
    logic fit;
    assign r_in = {sq_rem[k-1][RT-1:0], sq_x[k-1][2*B+1 -: 2]};
    assign trial = {sq_root[k-1], 2'b01};
    assign fit = r_in >= trial;
    always_ff @(posedge clk) begin
      sq_root[k] <= {sq_root[k-1][RT-2:0], fit};
    end
    if (k < RT) begin : g_carry
      always_ff @(posedge clk) begin
        sq_rem[k] <= fit ? r_in - trial : r_in;
        sq_x[k] <= sq_x[k-1];
      end
    end
  end

  // result register
  logic [RT:0] rr;
  logic [31:0] f_cx, f_cy;
  logic f_satc, f_ovr, f_al, rad_sat;

  assign {f_cx, f_cy, f_satc, f_ovr, f_al} = sd9[RT];
  assign rr = ((RT+1)'(sq_root[RT]) + (RT+1)'(1)) >> 1;
  assign rad_sat = f_ovr || (rr[RT:32] != '0);

  always_ff @(posedge clk) begin
    if (f_al) begin
      center_x <= '0;
      center_y <= '0;
      circle_radius <= '0;
      aligned_error <= 1'b1;
      saturated <= 1'b0;
    end else begin
      center_x <= f_cx;
      center_y <= f_cy;
      circle_radius <= rad_sat ? 32'hFFFF_FFFF : rr[31:0];
      aligned_error <= 1'b0;
      saturated <= f_satc || rad_sat;
    end
  end

  `CCP_ASSERT_IMPL(a_latency, start && !busy, ##LAT done)
  `CCP_ASSERT_IMPL(a_aligned_zero, done && aligned_error, {center_x, center_y, circle_radius, saturated} == '0)
  `CCP_ASSERT_NEXT(a_thresh_write, cfg_wr, sine_threshold == $past(pwdata[15:0]))
endmodule

FILE: dv/circumcircle_from_three_points_tb.sv
// testbench for the circumcircle block: directed and random point triples, wide-integer predictor
`timescale 1ns / 1ps
module circumcircle_from_three_points_tb;
  import ccp_pkg::*;

  localparam int CB = 24;
  localparam int W = 320;
  localparam int LATENCY = 82;
  localparam logic [ADDR_BITS-1:0] ADDR_THRESH = ADDR_BITS'(REG_SINE_THRESHOLD) << 2;
  localparam logic [ADDR_BITS-1:0] ADDR_UNMAPPED = ADDR_BITS'(4);

  typedef struct packed {
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
  } tri_pts_t;

  typedef struct packed {
    logic signed [31:0] center_x, center_y;
    logic [31:0] radius;
    logic aligned, sat;
  } circle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] ax = '0, ay = '0, bx = '0, by = '0, cx_in = '0, cy_in = '0;
  logic done;
  logic signed [31:0] center_x, center_y;
  logic [31:0] circle_radius;
  logic aligned_error, saturated;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [15:0] thresh_model = THRESH_RESET;
  circle_t expected_circles[$];
  int errors = 0;
  int requests_sent = 0;
  int circles_checked = 0;
  int aligned_seen = 0;
  int sat_seen = 0;
  int idle_pct = 0;

  always #1 clk = ~clk;

  circumcircle_from_three_points u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ax(ax), .ay(ay), .bx(bx), .by(by), .cx_in(cx_in), .cy_in(cy_in),
    .done(done), .center_x(center_x), .center_y(center_y),
    .circle_radius(circle_radius), .aligned_error(aligned_error), .saturated(saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic logic signed [W-1:0] round_div(logic signed [W-1:0] n,
                                                     logic signed [W-1:0] d);
    logic signed [W-1:0] an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = ((an <<< 1) + ad) / (ad <<< 1);
    return ((n < 0) ^ (d < 0)) ? -q : q;
  endfunction

  function automatic logic signed [W-1:0] int_sqrt(logic signed [W-1:0] s);
    logic signed [W-1:0] res, cand;
    res = '0;
    for (int i = 127; i >= 0; i--) begin
      cand = res;
      cand[i] = 1'b1;
      if (cand * cand <= s) res = cand;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clip_center(logic signed [W-1:0] v, ref logic sat);
    if (v > 64'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sh80000000) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic circle_t solve_circle(tri_pts_t p, logic [15:0] th);
    logic signed [W-1:0] pax, pay, pbx, pby, pcx, pcy, thw;
    logic signed [W-1:0] ux, uy, vx, vy, ex, ey, cr, l1, l2, nv, d, ox, oy, s, r;
    circle_t c;
    logic sat;
    pax = W'(p.ax); pay = W'(p.ay); pbx = W'(p.bx); pby = W'(p.by);
    pcx = W'(p.cx); pcy = W'(p.cy);
    thw = {{(W-16){1'b0}}, th};
    ux = pbx - pax; uy = pby - pay;
    vx = pcx - pax; vy = pcy - pay;
    ex = pcx - pbx; ey = pcy - pby;
    cr = uy * ex - ux * ey;
    l1 = ux * ux + uy * uy;
    l2 = ex * ex + ey * ey;
    c = '0;
    if (l1 == 0 || l2 == 0 || cr == 0 || ((cr * cr) <<< 32) < thw * thw * l1 * l2) begin
      c.aligned = 1'b1;
      return c;
    end
    nv = vx * vx + vy * vy;
    d = (ux * vy - uy * vx) <<< 1;
    ox = round_div(vy * l1 - uy * nv, d);
    oy = round_div(ux * nv - vx * l1, d);
    s = ox * ox + oy * oy;
    r = (int_sqrt(s <<< 2) + W'(1)) >>> 1;
    sat = 1'b0;
    c.center_x = clip_center(pax + ox, sat);
    c.center_y = clip_center(pay + oy, sat);
    if (r > 64'shFFFFFFFF) begin
      sat = 1'b1;
      c.radius = 32'hFFFFFFFF;
    end else begin
      c.radius = r[31:0];
    end
    c.sat = sat;
    return c;
  endfunction

  // result checker
  always @(posedge clk) begin
    circle_t exp_c;
    if (!rst && done) begin
      if (expected_circles.size() == 0) begin
        $display("%0t: unexpected result center=(%0d,%0d) radius=%0d", $time,
                 center_x, center_y, circle_radius);
        errors++;
      end else begin
        exp_c = expected_circles.pop_front();
        circles_checked++;
        if (exp_c.aligned) aligned_seen++;
        if (exp_c.sat) sat_seen++;
        if (center_x !== exp_c.center_x) begin
          $display("%0t: center_x expected %0d actual %0d", $time, exp_c.center_x, center_x);
          errors++;
        end
        if (center_y !== exp_c.center_y) begin
          $display("%0t: center_y expected %0d actual %0d", $time, exp_c.center_y, center_y);
          errors++;
        end
        if (circle_radius !== exp_c.radius) begin
          $display("%0t: circle_radius expected %0d actual %0d", $time, exp_c.radius,
                   circle_radius);
          errors++;
        end
        if (aligned_error !== exp_c.aligned) begin
          $display("%0t: aligned_error expected %0b actual %0b", $time, exp_c.aligned,
                   aligned_error);
          errors++;
        end
        if (saturated !== exp_c.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, exp_c.sat, saturated);
          errors++;
        end
      end
    end
  end

  task automatic send_request(tri_pts_t p);
    logic taken;
    start <= 1'b1;
    ax <= p.ax; ay <= p.ay; bx <= p.bx; by <= p.by; cx_in <= p.cx; cy_in <= p.cy;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    expected_circles.push_back(solve_circle(p, thresh_model));
    requests_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_circles.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_BITS-1:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_THRESH) thresh_model = data[15:0];
  endtask

  task automatic apb_read_check(logic [ADDR_BITS-1:0] addr);
    logic [31:0] got;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    if (got[15:0] !== thresh_model) begin
      $display("%0t: sine_threshold readback expected %0d actual %0d", $time,
               thresh_model, got[15:0]);
      errors++;
    end
  endtask

  task automatic set_threshold(logic [15:0] th);
    wait_drain();
    apb_write(ADDR_THRESH, {16'h0, th});
    apb_read_check(ADDR_THRESH);
  endtask

  function automatic tri_pts_t make_pts(int a0, int a1, int b0, int b1, int c0, int c1);
    tri_pts_t p;
    p.ax = CB'(a0); p.ay = CB'(a1); p.bx = CB'(b0); p.by = CB'(b1);
    p.cx = CB'(c0); p.cy = CB'(c1);
    return p;
  endfunction

  function automatic int rand_coord();
    return $signed(CB'($urandom));
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic tri_pts_t random_pts();
    tri_pts_t p;
    int a0, a1, d0, d1, k, span;
    case ($urandom_range(5))
      0, 1: begin
        p = make_pts(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord());
      end
      2: begin
        span = 1 << $urandom_range(4, 14);
        p = make_pts(rand_span(span), rand_span(span), rand_span(span), rand_span(span),
                     rand_span(span), rand_span(span));
      end
      3, 4: begin
        // nearly straight line, turn set by a small nudge
        span = 1 << $urandom_range(6, 20);
        a0 = rand_span(1 << 21); a1 = rand_span(1 << 21);
        d0 = rand_span(span); d1 = rand_span(span);
        k = $urandom_range(1, 3);
        p = make_pts(a0, a1, a0 + d0, a1 + d1, a0 + d0 + k * d0 + rand_span(4),
                     a1 + d1 + k * d1 + rand_span(4));
      end
      default: begin
        // repeated point
        p = make_pts(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord());
        if ($urandom_range(1)) begin
          p.bx = p.ax; p.by = p.ay;
        end else begin
          p.cx = p.bx; p.cy = p.by;
        end
      end
    endcase
    return p;
  endfunction

  task automatic test_directed();
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    idle_pct = 0;
    send_request(make_pts(0, 0, 4096, 0, 0, 4096));
    send_request(make_pts(0, 0, 4096, 0, 4096, 4096));
    send_request(make_pts(mn, mn, mx, mn, mx, mx));
    send_request(make_pts(mx, mx, mn, mx, mn, mn));
    send_request(make_pts(mn, mx, mx, mn, mx, mx));
    send_request(make_pts(100, 200, 100, 200, 900, 50));
    send_request(make_pts(100, 200, 900, 50, 900, 50));
    send_request(make_pts(7, 7, 7, 7, 7, 7));
    send_request(make_pts(0, 0, 1000, 1000, 2000, 2000));
    send_request(make_pts(mn, mn, 0, 0, mx, mx));
    send_request(make_pts(mn, 0, 0, 1, mx, 0));
    send_request(make_pts(mn, 0, 0, 0, mx, 1));
    send_request(make_pts(0, 0, 1, 0, 0, 1));
    send_request(make_pts(-1, -1, 1, -1, -1, 1));
    send_request(make_pts(mn, mn, mn + 1, mn, mn, mn + 1));
    set_threshold(16'd0);
    send_request(make_pts(0, 0, 1000, 1000, 2000, 2000));
    send_request(make_pts(mn, 0, 0, 1, mx, 0));
    send_request(make_pts(mn, mn, 0, 0, mx, mx - 1));
    set_threshold(16'hFFFF);
    send_request(make_pts(0, 0, 4096, 0, 0, 4096));
    send_request(make_pts(0, 0, 4096, 0, 4096, 4096));
    send_request(make_pts(0, 0, 4096, 0, 8192, 4096));
    wait_drain();
    apb_write(ADDR_UNMAPPED, 32'h1234);
    apb_read_check(ADDR_THRESH);
    set_threshold(THRESH_RESET);
    send_request(make_pts(0, 0, 4096, 0, 0, 4096));
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) send_request(random_pts());
  endtask

  task automatic test_threshold_sweep();
    logic [15:0] ths[4];
    ths = '{16'd1, 16'd300, 16'(($urandom_range(65535))), 16'hFFFE};
    foreach (ths[i]) begin
      set_threshold(ths[i]);
      test_random(40, 10);
    end
    set_threshold(16'd0);
    test_random(40, 0);
    set_threshold(THRESH_RESET);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read_check(ADDR_THRESH);
    test_directed();
    test_random(300, 20);
    wait_drain();
    test_random(300, 55);
    test_random(200, 0);
    test_threshold_sweep();
    wait_drain();
    $display("%0d requests sent, %0d results checked (%0d aligned, %0d saturated)",
             requests_sent, circles_checked, aligned_seen, sat_seen);
    $display("covered point extremes, repeated points, straight lines and several thresholds");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
